// ----- hw/rtl/mcuv_pkg.sv -----
// shared types and constants for the corner texture-coordinate vertex splitter
package mcuv_pkg;

    localparam int VTX_W    = 12;
    localparam int CORNER_W = 13;
    localparam int UV_W     = 64;
    localparam int KEY_W    = VTX_W + UV_W;

    localparam int DEF_MAX_VERTS     = 4096;
    localparam int DEF_MAX_OUT_VERTS = 8192;
    localparam int DEF_TABLE_ENTRIES = 8192;

    typedef enum logic [1:0] {
        ACT_FIRST = 2'd0,
        ACT_REUSE = 2'd1,
        ACT_DUP   = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic [VTX_W-1:0]    vertex;
        logic [UV_W-1:0]     uv;
        logic [CORNER_W-1:0] target;
    } entry_t;

endpackage

// ----- hw/rtl/mesh_corner_uv_vertex_split.sv -----
// top level: per-corner vertex split with a hashed (vertex, uv) pair table
//
// Each corner beat is looked up in a linearly probed pair table held in a
// synchronous memory, next to a one-bit-per-vertex seen memory. A corner's
// result is registered after its last probe of the table (one memory read
// per cycle, at least one probe, at most TABLE_ENTRIES); a new corner is
// accepted in the cycle after the previous result is registered. The result
// register lets the next corner start while a result still waits; that
// corner then holds at its last probe until the waiting result is taken.
// After reset each memory is cleared over its whole depth, one entry a
// cycle; no corner is accepted until the clear is done, vertex_count writes
// are. A corner whose vertex index is out of range, or that needs a table
// entry or a duplicate number that is not left, gets overflow set and
// changes nothing.
module mesh_corner_uv_vertex_split #(
    parameter int MAX_VERTS     = mcuv_pkg::DEF_MAX_VERTS,
    parameter int MAX_OUT_VERTS = mcuv_pkg::DEF_MAX_OUT_VERTS,
    parameter int TABLE_ENTRIES = mcuv_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcuv_pkg::CORNER_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mcuv_pkg::VTX_W-1:0]    vertex_index,
    input  logic [31:0]                   u_bits,
    input  logic [31:0]                   v_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mcuv_pkg::CORNER_W-1:0] corner_vertex,
    output logic [1:0]                    action,
    output logic [mcuv_pkg::VTX_W-1:0]    source_vertex,
    output logic                          overflow
);
    import mcuv_pkg::*;

    localparam int SW      = $clog2(MAX_VERTS);
    localparam int TW      = $clog2(TABLE_ENTRIES);
    localparam int UW      = $clog2(TABLE_ENTRIES + 1);
    localparam int DW      = $clog2(MAX_OUT_VERTS + 1);
    localparam int CLR_LEN = (TABLE_ENTRIES > MAX_VERTS) ? TABLE_ENTRIES : MAX_VERTS;
    localparam int CW      = $clog2(CLR_LEN);
    localparam int XW      = 17;
    localparam int FW      = 18;
    localparam int CHUNKS  = (KEY_W + TW - 1) / TW;

    // memories
    logic   seen_mem [MAX_VERTS];
    entry_t ent_mem  [TABLE_ENTRIES];
    logic   seen_q;
    entry_t ent_q;

    logic          seen_we, seen_wd, ent_we;
    logic [SW-1:0] seen_waddr, seen_raddr;
    logic [TW-1:0] ent_waddr, ent_raddr;
    entry_t        ent_wd;

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wd;
        end
        seen_q <= seen_mem[seen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wd;
        end
        ent_q <= ent_mem[ent_raddr];
    end

    // control and working registers
    state_t                state_reg, state_next;
    logic [CW-1:0]         clr_reg, clr_next;
    logic [CORNER_W-1:0]   vcount_reg;
    logic [DW-1:0]         dups_reg, dups_next;
    logic [TW-1:0]         slot_reg, slot_next;
    logic [UW-1:0]         probes_reg, probes_next;
    logic [VTX_W-1:0]      vtx_reg;
    logic [UV_W-1:0]       uv_reg;
    logic                  bad_reg;
    logic                  ovalid_reg, ovalid_next;
    logic [CORNER_W-1:0]   ocorner_reg, ocorner_next;
    action_t               oact_reg, oact_next;
    logic [VTX_W-1:0]      osrc_reg, osrc_next;
    logic                  oovf_reg, oovf_next;

    logic                  accept, out_free;
    logic [XW-1:0]         vtx_wide, vtx_reg_wide;
    logic [KEY_W-1:0]      key;
    logic [TW-1:0]         fold;
    logic [TW:0]           fold_w;
    logic [TW-1:0]         start;
    logic [TW-1:0]         slot_inc;
    logic [FW-1:0]         fresh;
    logic                  match, empty, exhausted;

    assign cfg_ready     = 1'b1;
    assign out_valid     = ovalid_reg;
    assign corner_vertex = ocorner_reg;
    assign action        = oact_reg;
    assign source_vertex = osrc_reg;
    assign overflow      = oovf_reg;

    assign vtx_wide     = XW'(vertex_index);
    assign vtx_reg_wide = XW'(vtx_reg);
    assign key          = {vertex_index, u_bits, v_bits};
    assign out_free     = !ovalid_reg || out_ready;

    // xor fold of the pair key, then one conditional subtract into range
    always_comb
    begin
        fold = '0;
        for (int c = 0; c < CHUNKS; c++)
        begin
            for (int b = 0; b < TW; b++)
            begin
                if (c * TW + b < KEY_W)
                begin
                    fold[b] = fold[b] ^ key[c * TW + b];
                end
            end
        end
        fold_w = {1'b0, fold};
        if (fold_w >= (TW + 1)'(TABLE_ENTRIES))
        begin
            fold_w = fold_w - (TW + 1)'(TABLE_ENTRIES);
        end
        start = fold_w[TW-1:0];
    end

    assign slot_inc  = (slot_reg == TW'(TABLE_ENTRIES - 1)) ? '0 : slot_reg + 1'b1;
    assign fresh     = FW'(vcount_reg) + FW'(dups_reg);
    assign match     = ent_q.valid && (ent_q.vertex == vtx_reg) && (ent_q.uv == uv_reg);
    assign empty     = !ent_q.valid;
    assign exhausted = (probes_reg == UW'(TABLE_ENTRIES));

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        dups_next    = dups_reg;
        slot_next    = slot_reg;
        probes_next  = probes_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ocorner_next = ocorner_reg;
        oact_next    = oact_reg;
        osrc_next    = osrc_reg;
        oovf_next    = oovf_reg;
        in_ready     = 1'b0;
        accept       = 1'b0;
        seen_we      = 1'b0;
        seen_wd      = 1'b0;
        seen_waddr   = vtx_reg_wide[SW-1:0];
        seen_raddr   = vtx_reg_wide[SW-1:0];
        ent_we       = 1'b0;
        ent_waddr    = slot_reg;
        ent_wd       = '{valid: 1'b1, vertex: vtx_reg, uv: uv_reg,
                         target: CORNER_W'(vtx_reg)};
        ent_raddr    = slot_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                if ({1'b0, clr_reg} < (CW + 1)'(MAX_VERTS))
                begin
                    seen_we    = 1'b1;
                    seen_waddr = clr_reg[SW-1:0];
                end
                if ({1'b0, clr_reg} < (CW + 1)'(TABLE_ENTRIES))
                begin
                    ent_we       = 1'b1;
                    ent_waddr    = clr_reg[TW-1:0];
                    ent_wd.valid = 1'b0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CW'(CLR_LEN - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                accept     = in_valid;
                ent_raddr  = start;
                seen_raddr = vtx_wide[SW-1:0];
                if (in_valid)
                begin
                    slot_next   = start;
                    probes_next = UW'(1);
                    state_next  = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (!bad_reg && !match && !empty && !exhausted)
                begin
                    // keep walking the probe chain
                    slot_next   = slot_inc;
                    ent_raddr   = slot_inc;
                    probes_next = probes_reg + 1'b1;
                end
                else if (out_free)
                begin
                    state_next   = ST_IDLE;
                    ovalid_next  = 1'b1;
                    ocorner_next = CORNER_W'(vtx_reg);
                    oact_next    = ACT_FIRST;
                    osrc_next    = vtx_reg;
                    oovf_next    = 1'b1;
                    if (bad_reg)
                    begin
                        oovf_next = 1'b1;
                    end
                    else if (!seen_q)
                    begin
                        if (empty)
                        begin
                            oovf_next = 1'b0;
                            seen_we   = 1'b1;
                            seen_wd   = 1'b1;
                            ent_we    = 1'b1;
                        end
                    end
                    else if (match)
                    begin
                        oovf_next    = 1'b0;
                        oact_next    = ACT_REUSE;
                        ocorner_next = ent_q.target;
                        osrc_next    = ent_q.vertex;
                    end
                    else if (empty && fresh < FW'(MAX_OUT_VERTS))
                    begin
                        oovf_next     = 1'b0;
                        oact_next     = ACT_DUP;
                        ocorner_next  = fresh[CORNER_W-1:0];
                        ent_we        = 1'b1;
                        ent_wd.target = fresh[CORNER_W-1:0];
                        dups_next     = dups_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            vcount_reg <= '0;
            dups_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            dups_reg   <= dups_next;
            ovalid_reg <= ovalid_next;
            if (cfg_valid)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        probes_reg  <= probes_next;
        ocorner_reg <= ocorner_next;
        oact_reg    <= oact_next;
        osrc_reg    <= osrc_next;
        oovf_reg    <= oovf_next;
        if (accept)
        begin
            vtx_reg <= vertex_index;
            uv_reg  <= {u_bits, v_bits};
            bad_reg <= (vtx_wide >= XW'(MAX_VERTS));
        end
    end

endmodule
